// ===== hw/rtl/bit_prefix_run_dictionary_decoder_top_defines.svh =====
// assertion macros shared by the decoder
`ifndef BIT_PREFIX_RUN_DICTIONARY_DECODER_TOP_DEFINES_SVH
`define BIT_PREFIX_RUN_DICTIONARY_DECODER_TOP_DEFINES_SVH

// checked on every edge out of reset
`define BPRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define BPRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/bprd_pkg.sv =====
`default_nettype none

package bprd_pkg;

    localparam int unsigned DICT_ENTRIES = 16;
    localparam int unsigned SYM_W        = 8;
    localparam int unsigned OFF_W        = $clog2(DICT_ENTRIES);
    localparam int unsigned RUN_W        = 2;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned DICT_HIGH_W  = 56;
    localparam int unsigned CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DICT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DICT_HIGH = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bprd_dict.sv =====
`default_nettype none

module bprd_dict
    import bprd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_write_t       cfg,
    input  logic [OFF_W-1:0] offset,
    output logic [SYM_W-1:0] symbol
);

    logic [CFG_DATA_W-1:0]         low_reg;
    logic [DICT_HIGH_W-1:0]        high_reg;
    logic [SYM_W*DICT_ENTRIES-1:0] entries;

    // entry 0 is the constant zero byte below entry 1
    assign entries = {high_reg, low_reg, {SYM_W{1'b0}}};
    assign symbol  = entries[{offset, 3'b000} +: SYM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cfg.wr_en)
        begin
            case (cfg.index)
                CFG_DICT_LOW:  low_reg  <= cfg.data;
                CFG_DICT_HIGH: high_reg <= cfg.data[DICT_HIGH_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bit_prefix_run_dictionary_decoder_top.sv =====
// code bits decode MSB first from a shift register, one per cycle when output is free
// a byte holds the input through load, bit steps, run copies past the first and flush
// output stalls can hold it longer, and the byte that carries the end code may end early
// the decoded words of a byte trail its bits by one pending slot and one output register
// last word of a byte is loaded in its flush state, once the output register is free
// reset (rst_n low, async) clears control state, the end flag and the dictionary to zero
`default_nettype none
`include "bit_prefix_run_dictionary_decoder_top_defines.svh"

module bit_prefix_run_dictionary_decoder_top
    import bprd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SYM_W-1:0]      code_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  out_kind,
    output logic [SYM_W-1:0]      out_byte,
    output logic                  last_of_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_REPEAT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_SECOND,
        PH_LITERAL,
        PH_RUNFIELD
    } phase_t;

    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [3:0] LIT_BITS  = 4'd8;
    localparam logic [3:0] RUN_BITS  = 4'd6;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [SYM_W-1:0] byte_reg, byte_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [3:0]       taken_reg, taken_next;
    logic [SYM_W-1:0] field_reg, field_next;
    logic             ended_reg, ended_next;
    logic [RUN_W-1:0] rep_reg, rep_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_kind_reg, pend_kind_next;
    logic [SYM_W-1:0] pend_byte_reg, pend_byte_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [SYM_W-1:0] out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    cfg_write_t       cfg;
    logic [SYM_W-1:0] dict_sym;
    logic             cur_bit;
    logic [SYM_W-1:0] field_in;
    logic [3:0]       taken_inc;
    logic [RUN_W-1:0] run_val;
    logic [OFF_W-1:0] off_val;
    logic             out_free;
    logic             gen_ok;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign cur_bit   = byte_reg[SYM_W-1];
    // field bits enter at the top so the first one ends up least significant
    assign field_in  = {cur_bit, field_reg[SYM_W-1:1]};
    assign taken_inc = taken_reg + 4'd1;
    assign run_val   = field_in[3:2];
    assign off_val   = field_in[SYM_W-1:SYM_W-OFF_W];

    bprd_dict u_dict (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .offset (off_val),
        .symbol (dict_sym)
    );

    // output register frees up this cycle, so the pending word may move on
    assign out_free = !out_valid_reg || !out_stall;
    assign gen_ok   = !pend_valid_reg || out_free;

    always_comb
    begin
        logic             gen;
        logic             gen_kind;
        logic [SYM_W-1:0] gen_byte;

        gen             = 1'b0;
        gen_kind        = KIND_DATA;
        gen_byte        = '0;
        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        cnt_next        = cnt_reg;
        taken_next      = taken_reg;
        field_next      = field_reg;
        ended_next      = ended_reg;
        rep_next        = rep_reg;
        sym_next        = sym_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ended_reg)
                begin
                    byte_next  = code_byte;
                    cnt_next   = '0;
                    state_next = ST_BITS;
                end
            end

            ST_BITS:
            begin
                logic need;
                logic advance;

                need = ((phase_reg == PH_SECOND) && !cur_bit)
                    || ((phase_reg == PH_LITERAL) && (taken_inc == LIT_BITS))
                    || ((phase_reg == PH_RUNFIELD) && (taken_inc == RUN_BITS));
                advance = !need || gen_ok;

                if (advance)
                begin
                    byte_next = {byte_reg[SYM_W-2:0], 1'b0};
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_reg + 4'd1 == BYTE_BITS)
                        state_next = ST_FLUSH;

                    case (phase_reg)
                        PH_SECOND:
                        begin
                            if (!cur_bit)
                            begin
                                gen        = 1'b1;
                                phase_next = PH_PREFIX;
                            end
                            else
                            begin
                                phase_next = PH_RUNFIELD;
                                taken_next = '0;
                                field_next = '0;
                            end
                        end

                        PH_LITERAL:
                        begin
                            field_next = field_in;
                            taken_next = taken_inc;
                            if (taken_inc == LIT_BITS)
                            begin
                                gen        = 1'b1;
                                gen_byte   = field_in;
                                phase_next = PH_PREFIX;
                                taken_next = '0;
                                field_next = '0;
                            end
                        end

                        PH_RUNFIELD:
                        begin
                            field_next = field_in;
                            taken_next = taken_inc;
                            if (taken_inc == RUN_BITS)
                            begin
                                gen        = 1'b1;
                                phase_next = PH_PREFIX;
                                taken_next = '0;
                                field_next = '0;
                                if (run_val == '0 && off_val == '0)
                                begin
                                    // end code: rest of this byte is dropped
                                    gen_kind   = KIND_END;
                                    ended_next = 1'b1;
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    gen_byte = dict_sym;
                                    sym_next = dict_sym;
                                    rep_next = run_val;
                                    if (run_val != '0)
                                        state_next = ST_REPEAT;
                                end
                            end
                        end

                        default:
                        begin
                            taken_next = '0;
                            field_next = '0;
                            phase_next = cur_bit ? PH_SECOND : PH_LITERAL;
                        end
                    endcase
                end
            end

            ST_REPEAT:
            begin
                if (gen_ok)
                begin
                    gen      = 1'b1;
                    gen_byte = sym_reg;
                    rep_next = rep_reg - 1'b1;
                    if (rep_reg == RUN_W'(1))
                        state_next = (cnt_reg == BYTE_BITS) ? ST_FLUSH : ST_BITS;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_byte_next   = pend_byte_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        // a new word pushes the held one out, which is then known not to be last
        if (gen)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = gen_kind;
            pend_byte_next  = gen_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_PREFIX;
            cnt_reg        <= '0;
            taken_reg      <= '0;
            field_reg      <= '0;
            ended_reg      <= 1'b0;
            rep_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            taken_reg      <= taken_next;
            field_reg      <= field_next;
            ended_reg      <= ended_next;
            rep_reg        <= rep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        sym_reg       <= sym_next;
        pend_kind_reg <= pend_kind_next;
        pend_byte_reg <= pend_byte_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = out_last_reg;

    `BPRD_ASSERT_ALWAYS(a_idle_no_pending, (state_reg == ST_IDLE) |-> !pend_valid_reg, "word left pending while idle")
    `BPRD_ASSERT(a_repeat_count, (state_reg == ST_REPEAT) |-> (rep_reg != '0), "repeat state with no copies left")
    `BPRD_ASSERT(a_bits_in_range, (state_reg == ST_BITS) |-> !cnt_reg[3], "bit loop ran past the byte")
    `BPRD_ASSERT(a_ended_stays_idle, (ended_reg && state_reg == ST_IDLE) |=> (state_reg == ST_IDLE), "decoder woke after end of stream")

endmodule

`default_nettype wire
